>>> src/ille_pkg.sv
// Shared types, constants and helpers for the indexed linked list engine.
// Depends on nothing; every other file of the block refers to it by scoped names.
package ille_pkg;

	// Table depth and id width
	localparam int NODES  = 1024;
	localparam int ID_W   = 10;
	localparam int ADDR_W = $clog2(NODES);

	// Stream widths: input tdata is target, new_id, side; output tdata is read_id
	localparam int IN_BITS   = 2 * ID_W + 1;
	localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((ID_W + 7) / 8) * 8;
	localparam int CMD_W     = 2;
	localparam int STAT_W    = 2;

	// Command queue between front and back
	localparam int QD   = 2;
	localparam int QA   = $clog2(QD);
	localparam int QC_W = $clog2(QD + 1);

	// Command codes
	localparam logic [CMD_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [CMD_W-1:0] OP_REMOVE  = 2'd1;
	localparam logic [CMD_W-1:0] OP_RESTART = 2'd2;
	localparam logic [CMD_W-1:0] OP_READ    = 2'd3;

	// Status codes
	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_END     = 2'd2;

	typedef struct packed {
		logic lnk;
		logic kpt;
	} flag_t;

	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic [ID_W-1:0]  target;
		logic [ID_W-1:0]  new_id;
		logic             side;
		logic             tgt_ok;
		logic             new_ok;
	} cmd_item_t;

	typedef struct packed {
		logic      valid;
		cmd_item_t item;
	} q_head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} bk_ctl_t;

	// Nonzero and inside the tables
	function automatic logic id_ok(input logic [ID_W-1:0] id);
		return (id != '0) && (int'(id) < NODES);
	endfunction

	function automatic logic [ADDR_W-1:0] to_addr(input logic [ID_W-1:0] id);
		return ADDR_W'(id);
	endfunction

endpackage

>>> src/ille_front.sv
// Front part: takes command words, decodes and range-checks the ids, queues them.
// Depends on ille_pkg.
module ille_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ille_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [ille_pkg::CMD_W-1:0]     s_tuser,
	input  ille_pkg::bk_ctl_t              ctl,
	output ille_pkg::q_head_t              head
);

	ille_pkg::cmd_item_t          q_mem [ille_pkg::QD];
	logic [ille_pkg::QA-1:0]      wr_ptr_q;
	logic [ille_pkg::QA-1:0]      rd_ptr_q;
	logic [ille_pkg::QC_W-1:0]    cnt_q;
	ille_pkg::cmd_item_t          in_item;
	logic                         push;

	always_comb begin
		in_item.op     = s_tuser;
		in_item.target = s_tdata[ille_pkg::ID_W-1:0];
		in_item.new_id = s_tdata[2*ille_pkg::ID_W-1:ille_pkg::ID_W];
		in_item.side   = s_tdata[2*ille_pkg::ID_W];
		in_item.tgt_ok = ille_pkg::id_ok(in_item.target);
		in_item.new_ok = ille_pkg::id_ok(in_item.new_id);
	end

	assign s_tready   = (cnt_q != ille_pkg::QC_W'(ille_pkg::QD)) && !ctl.clearing;
	assign push       = s_tvalid && s_tready;
	assign head.valid = (cnt_q != '0);
	assign head.item  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ille_pkg::QA'(ille_pkg::QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= (rd_ptr_q == ille_pkg::QA'(ille_pkg::QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, ctl.pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> src/ille_back.sv
// Back part: link and flag tables, command sequencer, read cursor, result register.
// Depends on ille_pkg.
module ille_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ille_pkg::q_head_t           head,
	output ille_pkg::bk_ctl_t           ctl,
	output logic                        m_valid,
	input  logic                        m_tready,
	output logic [ille_pkg::STAT_W-1:0] m_status,
	output logic [ille_pkg::ID_W-1:0]   m_rid
);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_INS_A = 3'd2;
	localparam logic [2:0] S_INS_B = 3'd3;
	localparam logic [2:0] S_INS_C = 3'd4;
	localparam logic [2:0] S_REM   = 3'd5;
	localparam logic [2:0] S_RD    = 3'd6;

	localparam int AW = ille_pkg::ADDR_W;
	localparam int IW = ille_pkg::ID_W;

	logic [IW-1:0]      nxt_mem [ille_pkg::NODES];
	logic [IW-1:0]      prv_mem [ille_pkg::NODES];
	ille_pkg::flag_t    flg_mem [ille_pkg::NODES];

	logic [2:0]         state_q, state_d;
	logic [AW-1:0]      clr_q;
	logic [IW-1:0]      cur_q, cur_d;
	logic [IW-1:0]      first_q, first_d;
	logic [IW-1:0]      tgt_q, new_q;
	logic               side_q, tgt_ok_q, new_ok_q;
	ille_pkg::flag_t    t_flg_q;
	logic [IW-1:0]      t_prv_q, t_nxt_q;
	ille_pkg::flag_t    flg_rd_q;
	logic [IW-1:0]      nxt_rd_q, prv_rd_q;

	logic [AW-1:0]      rd_addr;
	logic               nxt_we, prv_we, flg_we;
	logic [AW-1:0]      nxt_wa, prv_wa, flg_wa;
	logic [IW-1:0]      nxt_wd, prv_wd;
	ille_pkg::flag_t    flg_wd;
	logic               res_load;
	logic [ille_pkg::STAT_W-1:0] res_status;
	logic [IW-1:0]      res_rid;
	logic               out_free, pop, ins_ok, rem_ok;
	logic [IW-1:0]      nb;

	logic               m_valid_q;
	logic [ille_pkg::STAT_W-1:0] m_status_q;
	logic [IW-1:0]      m_rid_q;

	assign out_free     = !m_valid_q || m_tready;
	assign pop          = (state_q == S_IDLE) && head.valid && out_free;
	assign ctl.pop      = pop;
	assign ctl.clearing = (state_q == S_CLR);
	assign nb           = side_q ? t_nxt_q : t_prv_q;
	assign ins_ok       = tgt_ok_q && t_flg_q.lnk && new_ok_q && !flg_rd_q.lnk;
	assign rem_ok       = tgt_ok_q && flg_rd_q.lnk;

	always_comb begin
		state_d    = state_q;
		cur_d      = cur_q;
		first_d    = first_q;
		rd_addr    = ille_pkg::to_addr(head.item.target);
		nxt_we     = 1'b0;
		prv_we     = 1'b0;
		flg_we     = 1'b0;
		nxt_wa     = ille_pkg::to_addr(new_q);
		prv_wa     = ille_pkg::to_addr(new_q);
		flg_wa     = ille_pkg::to_addr(new_q);
		nxt_wd     = tgt_q;
		prv_wd     = tgt_q;
		flg_wd     = '{lnk: 1'b1, kpt: 1'b1};
		res_load   = 1'b0;
		res_status = ille_pkg::ST_DONE;
		res_rid    = '0;
		case (state_q)
			S_CLR: begin
				nxt_we = 1'b1;
				prv_we = 1'b1;
				flg_we = 1'b1;
				nxt_wa = clr_q;
				prv_wa = clr_q;
				flg_wa = clr_q;
				nxt_wd = '0;
				prv_wd = '0;
				flg_wd = '{lnk: (clr_q == AW'(1)), kpt: 1'b1};
				if (clr_q == AW'(ille_pkg::NODES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (pop) begin
					case (head.item.op)
						ille_pkg::OP_INSERT: state_d = S_INS_A;
						ille_pkg::OP_REMOVE: state_d = S_REM;
						ille_pkg::OP_RESTART: begin
							cur_d    = first_q;
							res_load = 1'b1;
						end
						ille_pkg::OP_READ: begin
							rd_addr = ille_pkg::to_addr(cur_q);
							state_d = S_RD;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS_A: begin
				rd_addr = ille_pkg::to_addr(new_q);
				state_d = S_INS_B;
			end
			S_INS_B: begin
				if (ins_ok) begin
					nxt_we  = 1'b1;
					prv_we  = 1'b1;
					flg_we  = 1'b1;
					nxt_wd  = side_q ? t_nxt_q : tgt_q;
					prv_wd  = side_q ? tgt_q : t_prv_q;
					state_d = S_INS_C;
				end else begin
					res_load   = 1'b1;
					res_status = ille_pkg::ST_INVALID;
					state_d    = S_IDLE;
				end
			end
			S_INS_C: begin
				nxt_wd = new_q;
				prv_wd = new_q;
				if (side_q) begin
					nxt_we = 1'b1;
					nxt_wa = ille_pkg::to_addr(tgt_q);
					prv_we = (nb != '0);
					prv_wa = ille_pkg::to_addr(nb);
				end else begin
					prv_we = 1'b1;
					prv_wa = ille_pkg::to_addr(tgt_q);
					nxt_we = (nb != '0);
					nxt_wa = ille_pkg::to_addr(nb);
					if (nb == '0) begin
						first_d = new_q;
					end
				end
				res_load = 1'b1;
				state_d  = S_IDLE;
			end
			S_REM: begin
				flg_we     = rem_ok;
				flg_wa     = ille_pkg::to_addr(tgt_q);
				flg_wd     = '{lnk: 1'b1, kpt: 1'b0};
				res_load   = 1'b1;
				res_status = rem_ok ? ille_pkg::ST_DONE : ille_pkg::ST_INVALID;
				state_d    = S_IDLE;
			end
			S_RD: begin
				if (!((cur_q != '0) && flg_rd_q.lnk)) begin
					cur_d      = '0;
					res_load   = 1'b1;
					res_status = ille_pkg::ST_END;
					state_d    = S_IDLE;
				end else if (flg_rd_q.kpt) begin
					cur_d    = nxt_rd_q;
					res_load = 1'b1;
					res_rid  = cur_q;
					state_d  = S_IDLE;
				end else begin
					cur_d   = nxt_rd_q;
					rd_addr = ille_pkg::to_addr(nxt_rd_q);
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Tables: one write and one registered read each
	always_ff @(posedge clk) begin
		if (nxt_we) begin
			nxt_mem[nxt_wa] <= nxt_wd;
		end
		nxt_rd_q <= nxt_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (prv_we) begin
			prv_mem[prv_wa] <= prv_wd;
		end
		prv_rd_q <= prv_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (flg_we) begin
			flg_mem[flg_wa] <= flg_wd;
		end
		flg_rd_q <= flg_mem[rd_addr];
	end

	// Command and anchor payload, and the result word
	always_ff @(posedge clk) begin
		if (pop) begin
			tgt_q    <= head.item.target;
			new_q    <= head.item.new_id;
			side_q   <= head.item.side;
			tgt_ok_q <= head.item.tgt_ok;
			new_ok_q <= head.item.new_ok;
		end
		if (state_q == S_INS_A) begin
			t_flg_q <= flg_rd_q;
			t_prv_q <= prv_rd_q;
			t_nxt_q <= nxt_rd_q;
		end
		if (res_load) begin
			m_status_q <= res_status;
			m_rid_q    <= res_rid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			cur_q     <= IW'(1);
			first_q   <= IW'(1);
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			first_q <= first_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_valid  = m_valid_q;
	assign m_status = m_status_q;
	assign m_rid    = m_rid_q;

	// Id zero must never look linked: reads rely on it to stop at a null link
	a_zero_unlinked: assert property (@(posedge clk) disable iff (!arst_n)
		(flg_we && (flg_wa == '0)) |-> !flg_wd.lnk)
		else $error("id zero marked linked");

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !pop)
		else $error("command taken during clearing pass");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result overwrites one not yet taken");

	a_ins_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_C) |-> ($past(state_q) == S_INS_B))
		else $error("link update without checked insert");

	a_rid_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && (res_status != ille_pkg::ST_DONE)) |-> (res_rid == '0))
		else $error("read id on a failed command");

endmodule

>>> src/indexed_linked_list_engine.sv
// Top level of the indexed linked list engine: stream ports, front queue and back sequencer.
// Depends on ille_pkg, ille_front and ille_back.
//
// The engine keeps an ordered list of ids as next and previous links in tables indexed by id;
// after reset the list holds id 1 alone. Each input word carries a command in tuser (insert,
// remove, restart readout, read next) and produces exactly one result word, whose tuser is the
// status (done, ignored because an id is invalid, end of list) and whose tdata is the id read,
// zero for everything but a successful read. After reset the engine runs a clearing pass over
// every table entry, during which s_tready stays low. A restart is answered as it is taken;
// remove reads the target's flags; insert reads the anchor and the new id, then writes links
// in two rounds, or stops after the reads if rejected; read steps over each removed node.
// These steps follow from the single read port of each link table and the dependent walk
// along next links; a short queue in front lets new words be taken while a result still waits
// on m_tready.
module indexed_linked_list_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ille_pkg::S_TDATA_W-1:0] s_tdata,   // target_id, new_id, side, zero pad
	input  logic [ille_pkg::CMD_W-1:0]     s_tuser,   // cmd
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ille_pkg::M_TDATA_W-1:0] m_tdata,   // read_id, zero pad
	output logic [ille_pkg::STAT_W-1:0]    m_tuser    // status
);

	ille_pkg::q_head_t          head;
	ille_pkg::bk_ctl_t          ctl;
	logic [ille_pkg::ID_W-1:0]  rid;

	// Decode and queue incoming words
	ille_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.ctl      (ctl),
		.head     (head)
	);

	// Carry out commands against the tables and hold the result word
	ille_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.ctl      (ctl),
		.m_valid  (m_tvalid),
		.m_tready (m_tready),
		.m_status (m_tuser),
		.m_rid    (rid)
	);

	// Widen the id to whole bytes
	assign m_tdata = ille_pkg::M_TDATA_W'(rid);

endmodule
